// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Depends on nothing; include once per asserting file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition is followed by a consequence on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mss_pkg.sv =====
// Package for the multi-stack shared store: beat types and codes.
// Used by the core top level; depends on nothing.
`timescale 1ns / 1ps

package mss_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [1:0]         stack_id;
    logic signed [31:0] push_value;
  } mss_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } mss_out_t;

endpackage

// ===== rtl/core/multi_stack_shared_store_core.sv =====
// Multi-stack shared store: stacks share one slot store, link RAM and free list.
// The result beat is registered as the beat leaves the write-back state entered on acceptance.
// A new beat is accepted only after the previous one finishes its link RAM read and write-back;
// a stalled output holds the write-back state until the result is taken.
// Reset: all stacks empty, free list 0..CAPACITY-1 via a fill counter, no sweep.
// Depends on mss_pkg, mss_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_stack_shared_store_core
  import mss_pkg::*;
#(
  parameter int NUM_STACKS = 4,
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mss_out_t out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [PW-1:0] NIL = PW'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WB   = 1'b1;

  logic                  state_q, state_d;
  logic                  op_q;
  logic [SW-1:0]         sid_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [PW-1:0]         slot_q;
  logic                  fault_q;
  logic                  out_valid_q, out_valid_d;
  mss_out_t              out_q, out_d;

  logic [PW-1:0] stack_head_q [NUM_STACKS];
  logic [PW-1:0] stack_head_d [NUM_STACKS];
  logic [PW-1:0] free_head_q, free_head_d;
  logic [PW-1:0] fill_q, fill_d;

  logic                  accept, commit, sid_ok, fault;
  logic [SW-1:0]         sid_idx;
  logic [PW-1:0]         slot_sel, link_rd, link_clamp, next_free, link_wdata;
  logic [DATA_WIDTH-1:0] data_rd;
  logic                  link_we, data_we;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_WB) && (!out_valid_q || out_ready_i);

  assign sid_ok   = 32'(in_data_i.stack_id) < NUM_STACKS;
  assign sid_idx  = SW'(in_data_i.stack_id);
  assign slot_sel = (in_data_i.operation == OP_PUSH) ? free_head_q :
                    (sid_ok ? stack_head_q[sid_idx] : NIL);
  assign fault    = !sid_ok || (slot_sel >= NIL);

  assign link_clamp = (link_rd > NIL) ? NIL : link_rd;
  assign next_free  = (slot_q >= fill_q) ? slot_q + PW'(1) : link_clamp;
  assign link_wdata = (op_q == OP_PUSH) ? stack_head_q[sid_q] : free_head_q;
  assign link_we    = commit && !fault_q;
  assign data_we    = commit && !fault_q && (op_q == OP_PUSH);

  mss_ram #(
    .WIDTH (PW),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (slot_q[AW-1:0]),
    .wdata_i (link_wdata),
    .re_i    (accept && !fault),
    .raddr_i (slot_sel[AW-1:0]),
    .rdata_o (link_rd)
  );

  mss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q[AW-1:0]),
    .wdata_i (val_q),
    .re_i    (accept && !fault),
    .raddr_i (slot_sel[AW-1:0]),
    .rdata_o (data_rd)
  );

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    stack_head_d = stack_head_q;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (commit) begin
          state_d           = S_IDLE;
          out_valid_d       = 1'b1;
          out_d.pop_value   = '0;
          out_d.status      = ST_OK;
          if (fault_q) begin
            out_d.status = (op_q == OP_PUSH) ? ST_FULL : ST_EMPTY;
          end else if (op_q == OP_PUSH) begin
            stack_head_d[sid_q] = slot_q;
            free_head_d         = next_free;
            if (slot_q >= fill_q) begin
              fill_d = fill_q + PW'(1);
            end
          end else begin
            stack_head_d[sid_q] = link_clamp;
            free_head_d         = slot_q;
            out_d.pop_value     = 32'($signed(data_rd));
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      free_head_q <= '0;
      fill_q      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_q[i] <= NIL;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      free_head_q  <= free_head_d;
      fill_q       <= fill_d;
      stack_head_q <= stack_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      op_q    <= in_data_i.operation;
      sid_q   <= sid_idx;
      val_q   <= DATA_WIDTH'($unsigned(in_data_i.push_value));
      slot_q  <= slot_sel;
      fault_q <= fault;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_free_within_fill, clk_i, rst_ni, free_head_q <= fill_q, "free head beyond fill count")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o, "ready high during write-back")
  `ASSERT_ALWAYS(a_fail_zero_value, clk_i, rst_ni, !out_valid_o || out_data_o.status == ST_OK || out_data_o.pop_value == 32'sd0, "failed beat carries a value")

endmodule

// ===== rtl/core/mss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module mss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for multi_stack_shared_store_core: push/pop beats go in
// on a valid/ready channel, result beats are compared with a model of the stacks.
// Depends on mss_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import mss_pkg::*;

  localparam int NSTK        = 4;
  localparam int CAP         = 16;
  localparam int NIL         = CAP;
  localparam int TOTAL_BEATS = 950;
  localparam int CALM_TAIL   = 150;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  mss_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  mss_out_t out_data_o;

  multi_stack_shared_store_core #(
    .NUM_STACKS(NSTK),
    .CAPACITY  (CAP),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Shadow of the shared store
  logic [31:0] store_word [CAP];
  logic [4:0]  store_link [CAP];
  logic [4:0]  top_slot   [NSTK];
  logic [4:0]  free_slot;

  typedef struct {
    mss_in_t  beat;
    bit       typed;
    mss_out_t want;
  } plan_row_t;

  plan_row_t plan_q[$];
  mss_out_t  pending_results[$];
  mss_out_t  oldest;

  bit src_pauses;
  bit sink_pauses;
  int fails;
  int beats_sent;
  int results_seen;
  int pushes_stored;
  int pops_returned;
  int refused_full;
  int refused_empty;

  function automatic mss_out_t apply_stack_op(mss_in_t beat);
    mss_out_t   res;
    logic [4:0] slot;
    logic [3:0] idx;
    res = '0;
    res.status = ST_OK;
    if (beat.operation == OP_PUSH) begin
      slot = free_slot;
      if (int'(beat.stack_id) >= NSTK || slot >= NIL) begin
        res.status = ST_FULL;
      end else begin
        idx = slot[3:0];
        free_slot = (store_link[idx] > NIL) ? 5'(NIL) : store_link[idx];
        store_word[idx] = beat.push_value;
        store_link[idx] = top_slot[beat.stack_id];
        top_slot[beat.stack_id] = slot;
      end
    end else begin
      if (int'(beat.stack_id) >= NSTK || top_slot[beat.stack_id] >= NIL) begin
        res.status = ST_EMPTY;
      end else begin
        slot = top_slot[beat.stack_id];
        idx = slot[3:0];
        top_slot[beat.stack_id] = (store_link[idx] > NIL) ? 5'(NIL) : store_link[idx];
        store_link[idx] = free_slot;
        free_slot = slot;
        res.pop_value = store_word[idx];
      end
    end
    return res;
  endfunction

  function automatic void plan_row(logic op, logic [1:0] sid, logic [31:0] val,
                                   bit typed = 1'b0, logic [1:0] st = ST_OK,
                                   logic [31:0] pv = '0);
    plan_row_t r;
    r.beat.operation  = op;
    r.beat.stack_id   = sid;
    r.beat.push_value = val;
    r.typed           = typed;
    r.want.status     = st;
    r.want.pop_value  = pv;
    plan_q.push_back(r);
  endfunction

  task automatic send_beat(input mss_in_t beat, input bit typed, input mss_out_t typed_want);
    mss_out_t predicted;
    if (src_pauses && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_stack_op(beat);
    pending_results.push_back(typed ? typed_want : predicted);
    beats_sent++;
    case (predicted.status)
      ST_FULL:  refused_full++;
      ST_EMPTY: refused_empty++;
      default: begin
        if (beat.operation == OP_PUSH) pushes_stored++;
        else pops_returned++;
      end
    endcase
  endtask

  // Result side: random stall bursts
  initial begin
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (sink_pauses && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d pop_value %h",
               out_data_o.status, out_data_o.pop_value);
        fails++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_data_o.status !== oldest.status) begin
          $error("status: expected %0d, actual %0d", oldest.status, out_data_o.status);
          fails++;
        end
        if (out_data_o.pop_value !== oldest.pop_value) begin
          $error("pop_value: expected %h, actual %h", oldest.pop_value, out_data_o.pop_value);
          fails++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL multi_stack_shared_store_core");
    $finish;
  end

  initial begin
    mss_in_t     beat;
    mss_out_t    none;
    plan_row_t   row;
    int          phase_len;
    int          push_pct;
    int          focus;
    bit          focused;
    logic [31:0] val;

    none        = '0;
    fails       = 0;
    beats_sent  = 0;
    src_pauses  = 1'b1;
    sink_pauses = 1'b1;
    rst_ni      = 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;

    for (int i = 0; i < CAP; i++) begin
      store_word[i] = '0;
      store_link[i] = 5'(i + 1);
    end
    for (int s = 0; s < NSTK; s++) top_slot[s] = 5'(NIL);
    free_slot = '0;

    // Empty after reset, fill the store, overflow, then drain the extremes
    for (int s = 0; s < NSTK; s++) plan_row(OP_POP, 2'(s), 32'hDEAD_BEEF, 1'b1, ST_EMPTY, '0);
    for (int i = 0; i < 12; i++) plan_row(OP_PUSH, 2'(i), 32'h0101_0101 * (i + 1));
    plan_row(OP_PUSH, 2'd0, 32'h7FFF_FFFF);
    plan_row(OP_PUSH, 2'd1, 32'h8000_0000);
    plan_row(OP_PUSH, 2'd2, 32'hFFFF_FFFF);
    plan_row(OP_PUSH, 2'd3, 32'h0000_0000);
    plan_row(OP_PUSH, 2'd1, 32'h1234_5678, 1'b1, ST_FULL,  '0);
    plan_row(OP_POP,  2'd0, 32'hFFFF_FFFF, 1'b1, ST_OK,    32'h7FFF_FFFF);
    plan_row(OP_POP,  2'd1, 32'h0000_0000, 1'b1, ST_OK,    32'h8000_0000);
    plan_row(OP_POP,  2'd2, 32'h5555_AAAA, 1'b1, ST_OK,    32'hFFFF_FFFF);
    plan_row(OP_POP,  2'd3, 32'hAAAA_5555, 1'b1, ST_OK,    32'h0000_0000);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan_q[i]) begin
      row = plan_q[i];
      send_beat(row.beat, row.typed, row.want);
    end

    // Phases lean towards filling, draining or mixing; stack focus optional
    while (beats_sent < TOTAL_BEATS) begin
      phase_len = $urandom_range(16, 64);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = 70;
      endcase
      focus   = $urandom_range(0, NSTK - 1);
      focused = 1'($urandom_range(0, 1));
      src_pauses  = (beats_sent < TOTAL_BEATS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      sink_pauses = (beats_sent < TOTAL_BEATS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len && beats_sent < TOTAL_BEATS; k++) begin
        case ($urandom_range(0, 7))
          0:       val = 32'h7FFF_FFFF;
          1:       val = 32'h8000_0000;
          2:       val = 32'hFFFF_FFFF;
          3:       val = 32'h0000_0000;
          4:       val = $urandom_range(0, 255);
          5:       val = -$urandom_range(1, 255);
          default: val = $urandom();
        endcase
        beat.operation  = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        beat.stack_id   = (focused && $urandom_range(0, 3) != 0) ? 2'(focus)
                                                                 : 2'($urandom_range(0, 3));
        beat.push_value = val;
        send_beat(beat, 1'b0, none);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d beats: %0d pushes stored, %0d pops returned data,", beats_sent,
             pushes_stored, pops_returned);
    $display("%0d pushes refused on a full store, %0d pops on an empty stack; %0d results checked.",
             refused_full, refused_empty, results_seen);
    if (fails == 0) begin
      $display("PASS multi_stack_shared_store_core");
    end else begin
      $display("FAIL multi_stack_shared_store_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mss_pkg.sv
rtl/core/mss_ram.sv
rtl/core/multi_stack_shared_store_core.sv
tb/sv/tb_top.sv
